// ----- sv/sorted_set_table_unit_macros.svh -----
// Assertion macros for the sorted set table unit.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef SORTED_SET_TABLE_UNIT_MACROS_SVH
`define SORTED_SET_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/sst_pkg.sv -----
// Shared types and codes for the sorted set table unit.
// No dependencies; imported by every module of the block.
package sst_pkg;

   localparam int DEF_CAPACITY  = 64;
   localparam int DEF_KEY_WIDTH = 32;

   localparam int REQ_KEY_W = 32;
   localparam int POS_W     = 7;
   localparam int RSP_CNT_W = 7;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_CLEAR  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_DUP     = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_MISSING = 3'd4,
      ST_RANGE   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // Shift commands broadcast to every cell of the chain.
   typedef struct packed {
      logic ins;
      logic del;
   } shift_ctl_type;

endpackage

// ----- sv/sst_cell.sv -----
// One cell of the sorted key chain: holds a single key and its compares.
// Depends on sst_pkg for the shift command type.
module sst_cell #(
   parameter int IDX       = 0,
   parameter int KEY_WIDTH = sst_pkg::DEF_KEY_WIDTH,
   parameter int CNT_W     = 7
) (
   input  logic                        clock,
   input  logic [KEY_WIDTH-1:0]        op_key,
   input  logic [sst_pkg::POS_W-1:0]   position,
   input  logic [CNT_W-1:0]            count,
   input  sst_pkg::shift_ctl_type      ctl,
   input  logic [KEY_WIDTH-1:0]        left_key,
   input  logic                        left_lt,
   input  logic [KEY_WIDTH-1:0]        right_key,
   output logic [KEY_WIDTH-1:0]        key_out,
   output logic                        lt_out,
   output logic                        hit,
   output logic [KEY_WIDTH-1:0]        rd_key
);
   import sst_pkg::*;

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 valid;
   logic                 sel;

   always_comb begin
      valid  = int'(count) > IDX;
      lt_out = valid && (key_ff < op_key);
      hit    = valid && (key_ff == op_key);
      sel    = valid && (int'(position) == IDX + 1);
      rd_key = sel ? key_ff : '0;
      key_in = key_ff;
      // cells below the insertion or deletion point keep their key
      if (ctl.ins && !lt_out) begin
         key_in = left_lt ? op_key : left_key;
      end else if (ctl.del && !lt_out) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;

endmodule

// ----- sv/sst_chain.sv -----
// Row of sst_cell instances with neighbour links and hit/read reductions.
// Depends on sst_pkg and sst_cell.
module sst_chain #(
   parameter int CAPACITY  = sst_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = sst_pkg::DEF_KEY_WIDTH,
   parameter int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic [KEY_WIDTH-1:0]        op_key,
   input  logic [sst_pkg::POS_W-1:0]   position,
   input  logic [CNT_W-1:0]            count,
   input  sst_pkg::shift_ctl_type      ctl,
   output logic                        any_hit,
   output logic [KEY_WIDTH-1:0]        rd_key
);
   import sst_pkg::*;

   logic [KEY_WIDTH-1:0] key_w [CAPACITY];
   logic [KEY_WIDTH-1:0] rd_w  [CAPACITY];
   logic [CAPACITY-1:0]  lt_w;
   logic [CAPACITY-1:0]  hit_w;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] lkey, rkey;
      logic                 llt;
      if (i == 0) begin : g_first
         // on an insert, the first cell always takes the new key when it is not below it
         assign lkey = op_key;
         assign llt  = 1'b1;
      end else begin : g_mid
         assign lkey = key_w[i-1];
         assign llt  = lt_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rkey = key_w[i];
      end else begin : g_nlast
         assign rkey = key_w[i+1];
      end
      sst_cell #(
         .IDX       (i),
         .KEY_WIDTH (KEY_WIDTH),
         .CNT_W     (CNT_W)
      ) u_cell (
         .clock     (clock),
         .op_key    (op_key),
         .position  (position),
         .count     (count),
         .ctl       (ctl),
         .left_key  (lkey),
         .left_lt   (llt),
         .right_key (rkey),
         .key_out   (key_w[i]),
         .lt_out    (lt_w[i]),
         .hit       (hit_w[i]),
         .rd_key    (rd_w[i])
      );
   end

   always_comb begin
      any_hit = |hit_w;
      rd_key  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_key = rd_key | rd_w[i];
      end
   end

endmodule

// ----- sv/sorted_set_table_unit.sv -----
// Sorted set table: distinct keys held in ascending order in a chain of cells.
// Each item is registered at the accepting edge, compared and shifted in S_EXEC, and
// its result is registered for rsp_strobe; busy is high while in S_EXEC, the compare/shift state.
// A new item is taken only in S_IDLE, never while busy; every cell compares and shifts at once.
// Synchronous active-high reset empties the set and idles the control; no sweep.
// Results cannot be stalled: each is shown for exactly one cycle with rsp_strobe.
`include "sorted_set_table_unit_macros.svh"

module sorted_set_table_unit #(
   parameter int CAPACITY  = sst_pkg::DEF_CAPACITY,
   parameter int KEY_WIDTH = sst_pkg::DEF_KEY_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [sst_pkg::REQ_KEY_W-1:0] req_key,
   input  logic [sst_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_strobe,
   output logic [2:0]                    rsp_status,
   output logic [31:0]                   rsp_value,
   output logic [sst_pkg::RSP_CNT_W-1:0] rsp_count
);
   import sst_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   mode_type             mode_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 strobe_ff;
   status_type           status_ff, status_in;
   logic [31:0]          value_ff, value_in;

   logic [63:0]          key_ext;
   logic [63:0]          rd_ext;
   logic                 accept;
   logic                 exec;
   logic                 full;
   logic                 any_hit;
   logic [KEY_WIDTH-1:0] rd_key;
   shift_ctl_type        ctl;

   assign accept  = start && (state_ff == S_IDLE);
   assign exec    = (state_ff == S_EXEC);
   assign busy    = exec;
   assign key_ext = 64'(req_key);
   assign full    = (count_ff == CNT_W'(CAPACITY));

   sst_chain #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W)
   ) u_chain (
      .clock    (clock),
      .op_key   (key_ff),
      .position (pos_ff),
      .count    (count_ff),
      .ctl      (ctl),
      .any_hit  (any_hit),
      .rd_key   (rd_key)
   );

   assign rd_ext = 64'(rd_key);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      value_in  = '0;
      ctl       = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            case (mode_ff)
               MODE_INSERT: begin
                  if (full) begin
                     status_in = ST_FULL;
                  end else if (any_hit) begin
                     status_in = ST_DUP;
                  end else begin
                     ctl.ins  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               MODE_DELETE: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else if (!any_hit) begin
                     status_in = ST_MISSING;
                  end else begin
                     ctl.del  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               MODE_READ: begin
                  if (pos_ff == '0 || int'(pos_ff) > int'(count_ff)) begin
                     status_in = ST_RANGE;
                  end else begin
                     value_in = rd_ext[31:0];
                  end
               end
               MODE_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  count_in = count_ff;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= exec;
      end
   end

   // hold the item for the compare cycle; result payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode_type'(req_mode);
         key_ff  <= key_ext[KEY_WIDTH-1:0];
         pos_ff  <= req_position;
      end
      if (exec) begin
         status_ff <= status_in;
         value_ff  <= value_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_count  = RSP_CNT_W'(count_ff);

   `SST_ASSERT_NEXT(a_exec_strobes, exec, strobe_ff && !exec, "compare cycle gave no result")
   `SST_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")
   `SST_ASSERT_NOW(a_count_cap, 1'b1, int'(count_ff) <= CAPACITY, "key count beyond capacity")
   `SST_ASSERT_NOW(a_full_count, strobe_ff && status_ff == ST_FULL,
      count_ff == CNT_W'(CAPACITY), "full status with room left")

endmodule

// ----- verif/sorted_set_table_unit_tb.sv -----
// Self-checking bench for sorted_set_table_unit: command items in, strobed results out.
// Depends on sst_pkg for mode and status codes; a scoreboard class predicts every result.
`timescale 1ns / 1ps

module sorted_set_table_unit_tb;
   import sst_pkg::*;

   localparam int CAP = DEF_CAPACITY;

   typedef struct {
      status_type  status;
      logic [31:0] value;
      logic [6:0]  count;
   } outcome_type;

   class set_scoreboard;
      logic [31:0] keys [CAP];
      int          held;
      outcome_type waiting [$];
      int          errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      // number of held keys strictly below k
      function int slot_of(logic [31:0] k);
         int i;
         i = 0;
         while (i < held && keys[i] < k) i++;
         return i;
      endfunction

      function void note_item(mode_type m, logic [31:0] k, logic [6:0] pos);
         outcome_type o;
         int          p;
         int          i;
         o.status = ST_OK;
         o.value  = '0;
         case (m)
            MODE_INSERT: begin
               if (held >= CAP) begin
                  o.status = ST_FULL;
               end else begin
                  p = slot_of(k);
                  if (p < held && keys[p] == k) begin
                     o.status = ST_DUP;
                  end else begin
                     for (i = held; i > p; i--) keys[i] = keys[i-1];
                     keys[p] = k;
                     held++;
                  end
               end
            end
            MODE_DELETE: begin
               if (held == 0) begin
                  o.status = ST_EMPTY;
               end else begin
                  p = slot_of(k);
                  if (p >= held || keys[p] != k) begin
                     o.status = ST_MISSING;
                  end else begin
                     for (i = p; i + 1 < held; i++) keys[i] = keys[i+1];
                     held--;
                  end
               end
            end
            MODE_READ: begin
               if (pos == 0 || int'(pos) > held) o.status = ST_RANGE;
               else o.value = keys[pos-1];
            end
            default: begin
               held = 0;
            end
         endcase
         o.count = 7'(held);
         waiting.push_back(o);
      endfunction

      function void check_result(logic [2:0] st, logic [31:0] v, logic [6:0] c);
         outcome_type o;
         if (waiting.size() == 0) begin
            $error("result with no item pending: status %0d value %h count %0d", st, v, c);
            errors++;
            return;
         end
         o = waiting.pop_front();
         if (st !== o.status) begin
            $error("status: expected %0d, got %0d", o.status, st);
            errors++;
         end
         if (v !== o.value) begin
            $error("value: expected %h, got %h", o.value, v);
            errors++;
         end
         if (c !== o.count) begin
            $error("count: expected %0d, got %0d", o.count, c);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [31:0] req_key;
   logic [6:0]  req_position;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_value;
   logic [6:0]  rsp_count;

   set_scoreboard sb;
   bit            allow_gaps;

   sorted_set_table_unit i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .req_position (req_position),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_value    (rsp_value),
      .rsp_count    (rsp_count)
   );

   always #4 clock = ~clock;

   // check results before noting the item taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_status, rsp_value, rsp_count);
         if (start && !busy) sb.note_item(mode_type'(req_mode), req_key, req_position);
      end
   end

   task automatic send_item(mode_type m, logic [31:0] k, logic [6:0] pos);
      req_mode     = m;
      req_key      = k;
      req_position = pos;
      start        = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (allow_gaps && $urandom_range(0, 99) < 33) begin
         start = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // hold off until every outstanding item has its result
   task automatic wait_drained();
      start = 1'b0;
      while (sb.waiting.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && sb.held > 0) return sb.keys[$urandom_range(0, sb.held - 1)];
      if (r < 70) begin
         if ($urandom_range(0, 1)) return 32'($urandom_range(0, 15));
         return ~32'($urandom_range(0, 15));
      end
      return $urandom();
   endfunction

   function automatic logic [6:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70 && sb.held > 0) return 7'($urandom_range(1, sb.held));
      if (r < 85) begin
         case ($urandom_range(0, 3))
            0: return 7'(sb.held);
            1: return 7'(sb.held + 1);
            2: return 7'(CAP);
            default: return 7'd0;
         endcase
      end
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic random_item(int ins_pct, int del_pct, int clr_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < ins_pct) send_item(MODE_INSERT, pick_key(), 7'($urandom_range(0, 127)));
      else if (r < ins_pct + del_pct)
         send_item(MODE_DELETE, pick_key(), 7'($urandom_range(0, 127)));
      else if (r < ins_pct + del_pct + clr_pct) send_item(MODE_CLEAR, $urandom(), pick_position());
      else send_item(MODE_READ, $urandom(), pick_position());
   endtask

   initial begin
      sb           = new();
      allow_gaps   = 1'b1;
      reset        = 1'b1;
      start        = 1'b0;
      req_mode     = MODE_INSERT;
      req_key      = '0;
      req_position = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corner cases on an empty, then a small, set
      send_item(MODE_CLEAR,  32'h0000_0000, 7'd0);
      send_item(MODE_DELETE, 32'h0000_0005, 7'd0);
      send_item(MODE_READ,   32'hFFFF_FFFF, 7'd0);
      send_item(MODE_READ,   32'h0000_0000, 7'd1);
      send_item(MODE_INSERT, 32'h8000_0000, 7'd127);
      send_item(MODE_INSERT, 32'h0000_0000, 7'd0);
      send_item(MODE_INSERT, 32'hFFFF_FFFF, 7'd0);
      send_item(MODE_INSERT, 32'h0000_0000, 7'd0);
      send_item(MODE_INSERT, 32'h7FFF_FFFF, 7'd0);
      send_item(MODE_READ,   32'h0000_0000, 7'd1);
      send_item(MODE_READ,   32'h0000_0000, 7'd2);
      send_item(MODE_READ,   32'h0000_0000, 7'd3);
      send_item(MODE_READ,   32'h0000_0000, 7'd4);
      send_item(MODE_READ,   32'h0000_0000, 7'd5);
      send_item(MODE_READ,   32'h0000_0000, 7'd127);
      send_item(MODE_DELETE, 32'h0000_1234, 7'd0);
      send_item(MODE_DELETE, 32'hFFFF_FFFF, 7'd0);
      send_item(MODE_DELETE, 32'h0000_0000, 7'd0);
      send_item(MODE_READ,   32'h0000_0000, 7'd2);
      send_item(MODE_CLEAR,  32'hFFFF_FFFF, 7'd127);
      send_item(MODE_READ,   32'h0000_0000, 7'd1);
      send_item(MODE_INSERT, 32'h5A5A_5A5A, 7'd64);
      wait_drained();

      // rounds: fill to full, churn, drain to empty; no gaps in rounds 3 and 4
      for (int round = 0; round < 10; round++) begin
         allow_gaps = (round != 3 && round != 4);
         for (int n = 0; n < 120; n++) begin
            case (round % 4)
               0: random_item(85, 5, 0);
               2: random_item(5, 80, 0);
               default: random_item(40, 35, 2);
            endcase
         end
         wait_drained();
      end

      start = 1'b0;
      while (sb.waiting.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.waiting.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
